FILE: sv/wcms_pkg.sv
// package: shared types, codes and reset constants for the wire clamp motor sequencer
`default_nettype none
package wcms_pkg;

    localparam int COUNTER_BITS_DEF = 16;

    localparam int TIMER_W = 16;
    localparam int DUTY_W  = 7;
    localparam int IDX_W   = 3;
    localparam int DATA_W  = 16;
    localparam int OP_W    = 3;
    localparam int MODE_W  = 2;

    localparam logic [TIMER_W-1:0] DEBOUNCE_TICKS_RST = 16'd1000;
    localparam logic [TIMER_W-1:0] MOTOR_TICKS_RST    = 16'd2800;
    localparam logic [TIMER_W-1:0] ENCODER_LIMIT_RST  = 16'd2400;
    localparam logic [DUTY_W-1:0]  MOTOR_DUTY_RST     = 7'd50;
    localparam logic               BEACON_LEVEL_RST   = 1'b0;
    localparam logic [DUTY_W-1:0]  DUTY_MAX           = 7'd100;

    typedef enum logic [OP_W-1:0] {
        OP_TICK      = 3'd0,
        OP_CABLE     = 3'd1,
        OP_ENCODER   = 3'd2,
        OP_ENGAGE    = 3'd3,
        OP_DISENGAGE = 3'd4
    } t_op;

    typedef enum logic [MODE_W-1:0] {
        MODE_OPEN        = 2'd0,
        MODE_DEBOUNCING  = 2'd1,
        MODE_CLOSED      = 2'd2,
        MODE_DISENGAGING = 2'd3
    } t_mode;

    typedef enum logic [3:0] {
        ST_OPEN        = 4'b0001,
        ST_DEBOUNCING  = 4'b0010,
        ST_CLOSED      = 4'b0100,
        ST_DISENGAGING = 4'b1000
    } t_state;

    typedef enum logic [IDX_W-1:0] {
        CFG_DEBOUNCE_TICKS = 3'd0,
        CFG_MOTOR_TICKS    = 3'd1,
        CFG_ENCODER_LIMIT  = 3'd2,
        CFG_MOTOR_DUTY     = 3'd3,
        CFG_BEACON_LEVEL   = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic [TIMER_W-1:0] debounce_ticks;
        logic [TIMER_W-1:0] motor_ticks;
        logic [TIMER_W-1:0] encoder_limit;
        logic [DUTY_W-1:0]  motor_duty;
        logic               beacon_level;
    } t_cfg;

    typedef struct packed {
        t_mode             mode;
        logic [DUTY_W-1:0] motor_duty_out;
        logic              motor_reverse;
        logic              magnet_on;
        logic              beacon_on;
    } t_status;

endpackage
`default_nettype wire

FILE: sv/wcms_if.sv
// interfaces: request, result and register write channels
`default_nettype none
interface wcms_req_if import wcms_pkg::*; ();
    logic            valid;
    logic            ready;
    logic [OP_W-1:0] operation;
    logic            pin_level;
    modport source (output valid, output operation, output pin_level, input ready);
    modport sink   (input valid, input operation, input pin_level, output ready);
endinterface

interface wcms_rsp_if import wcms_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [MODE_W-1:0] mode;
    logic [DUTY_W-1:0] motor_duty_out;
    logic              motor_reverse;
    logic              magnet_on;
    logic              beacon_on;
    modport source (output valid, output mode, output motor_duty_out, output motor_reverse,
                    output magnet_on, output beacon_on, input ready);
    modport sink   (input valid, input mode, input motor_duty_out, input motor_reverse,
                    input magnet_on, input beacon_on, output ready);
endinterface

interface wcms_cfg_if import wcms_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [IDX_W-1:0]  index;
    logic [DATA_W-1:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

FILE: sv/wcms_cfg.sv
// register file for the sequencer settings
`default_nettype none
module wcms_cfg import wcms_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_wr_valid,
    input  wire logic [IDX_W-1:0]  i_wr_index,
    input  wire logic [DATA_W-1:0] i_wr_data,
    output t_cfg                   o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_wr_valid) begin
            case (t_cfg_idx'(i_wr_index))
                CFG_DEBOUNCE_TICKS: n_cfg.debounce_ticks = i_wr_data[TIMER_W-1:0];
                CFG_MOTOR_TICKS:    n_cfg.motor_ticks    = i_wr_data[TIMER_W-1:0];
                CFG_ENCODER_LIMIT:  n_cfg.encoder_limit  = i_wr_data[TIMER_W-1:0];
                CFG_MOTOR_DUTY:     n_cfg.motor_duty     = i_wr_data[DUTY_W-1:0];
                CFG_BEACON_LEVEL:   n_cfg.beacon_level   = i_wr_data[0];
                default:            n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.debounce_ticks <= DEBOUNCE_TICKS_RST;
            r_cfg.motor_ticks    <= MOTOR_TICKS_RST;
            r_cfg.encoder_limit  <= ENCODER_LIMIT_RST;
            r_cfg.motor_duty     <= MOTOR_DUTY_RST;
            r_cfg.beacon_level   <= BEACON_LEVEL_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule
`default_nettype wire

FILE: sv/wcms_core.sv
// clamp state machine, timers and encoder counter with next-state logic
`default_nettype none
module wcms_core import wcms_pkg::*; #(
    parameter int COUNTER_BITS = COUNTER_BITS_DEF
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_fire,
    input  wire logic [OP_W-1:0] i_operation,
    input  wire logic            i_pin_level,
    input  t_cfg                 i_cfg,
    output t_status              o_status
);

    localparam int CMP_W = (COUNTER_BITS > TIMER_W) ? COUNTER_BITS : TIMER_W;

    t_state                  r_state,     n_state;
    logic [COUNTER_BITS-1:0] r_enc,       n_enc;
    logic [TIMER_W-1:0]      r_db_left,   n_db_left;
    logic                    r_db_act,    n_db_act;
    logic [TIMER_W-1:0]      r_mt_left,   n_mt_left;
    logic                    r_mt_act,    n_mt_act;
    logic                    r_next_rev,  n_next_rev;
    logic                    r_run,       n_run;
    logic                    r_dir,       n_dir;
    logic                    r_magnet,    n_magnet;
    logic                    r_beacon,    n_beacon;

    logic [TIMER_W-1:0]      db_load;
    logic [TIMER_W-1:0]      mt_load;
    logic [COUNTER_BITS-1:0] enc_inc;
    logic                    enc_over;
    logic                    mt_exp;
    logic                    db_exp;
    logic                    start;

    // zero load behaves as one
    assign db_load  = (i_cfg.debounce_ticks == '0) ? TIMER_W'(1) : i_cfg.debounce_ticks;
    assign mt_load  = (i_cfg.motor_ticks == '0) ? TIMER_W'(1) : i_cfg.motor_ticks;
    assign enc_inc  = (r_enc == '1) ? r_enc : r_enc + COUNTER_BITS'(1);
    assign enc_over = CMP_W'(enc_inc) > CMP_W'(i_cfg.encoder_limit);
    assign mt_exp   = r_mt_act && (r_mt_left <= TIMER_W'(1));
    assign db_exp   = r_db_act && (r_db_left <= TIMER_W'(1));

    always_comb begin
        n_state    = r_state;
        n_enc      = r_enc;
        n_db_left  = r_db_left;
        n_db_act   = r_db_act;
        n_mt_left  = r_mt_left;
        n_mt_act   = r_mt_act;
        n_next_rev = r_next_rev;
        n_run      = r_run;
        n_dir      = r_dir;
        n_magnet   = r_magnet;
        n_beacon   = r_beacon;
        start      = 1'b0;

        case (t_op'(i_operation))
            OP_TICK: begin
                if (r_mt_act) begin
                    n_mt_left = (r_mt_left == '0) ? '0 : r_mt_left - TIMER_W'(1);
                    n_mt_act  = !mt_exp;
                end
                if (r_db_act) begin
                    n_db_left = (r_db_left == '0) ? '0 : r_db_left - TIMER_W'(1);
                    n_db_act  = !db_exp;
                end
                // motor expiry is ignored while debouncing
                if (mt_exp && r_state != ST_DEBOUNCING) begin
                    n_run = 1'b0;
                    n_dir = 1'b0;
                    if (r_state == ST_CLOSED) begin
                        n_magnet = 1'b0;
                    end else if (r_state == ST_DISENGAGING) begin
                        n_magnet = 1'b1;
                    end
                end
                if (db_exp && r_state == ST_DEBOUNCING) begin
                    n_state  = ST_CLOSED;
                    start    = 1'b1;
                    n_magnet = 1'b0;
                    n_beacon = 1'b0;
                end
            end
            OP_CABLE: begin
                // level equal to the beacon level is a false alarm
                if (i_pin_level != i_cfg.beacon_level) begin
                    if (r_state == ST_OPEN) begin
                        n_db_left = db_load;
                        n_db_act  = 1'b1;
                        n_state   = ST_DEBOUNCING;
                    end else if (r_state == ST_DEBOUNCING || r_state == ST_DISENGAGING) begin
                        n_state = ST_OPEN;
                    end
                end
            end
            OP_ENCODER: begin
                n_enc = enc_inc;
                if (r_state != ST_DEBOUNCING && enc_over) begin
                    n_run    = 1'b0;
                    n_dir    = 1'b0;
                    n_mt_act = 1'b0;
                    if (r_state == ST_CLOSED) begin
                        n_enc    = '0;
                        n_magnet = 1'b0;
                    end else if (r_state == ST_DISENGAGING) begin
                        n_magnet = 1'b1;
                    end
                end
            end
            OP_ENGAGE: begin
                // re-engage closes at once
                if (r_state == ST_DISENGAGING) begin
                    n_state  = ST_CLOSED;
                    start    = 1'b1;
                    n_magnet = 1'b0;
                    n_beacon = 1'b0;
                end
            end
            OP_DISENGAGE: begin
                if (r_state == ST_CLOSED) begin
                    n_state  = ST_DISENGAGING;
                    start    = 1'b1;
                    n_beacon = 1'b1;
                end
            end
            default: begin
                n_state = r_state;
            end
        endcase

        if (start) begin
            n_dir      = r_next_rev;
            n_next_rev = !r_next_rev;
            n_run      = 1'b1;
            n_enc      = '0;
            n_mt_left  = mt_load;
            n_mt_act   = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_OPEN;
            r_enc      <= '0;
            r_db_left  <= '0;
            r_db_act   <= 1'b0;
            r_mt_left  <= '0;
            r_mt_act   <= 1'b0;
            r_next_rev <= 1'b1;
            r_run      <= 1'b0;
            r_dir      <= 1'b0;
            r_magnet   <= 1'b1;
            r_beacon   <= 1'b1;
        end else if (i_fire) begin
            r_state    <= n_state;
            r_enc      <= n_enc;
            r_db_left  <= n_db_left;
            r_db_act   <= n_db_act;
            r_mt_left  <= n_mt_left;
            r_mt_act   <= n_mt_act;
            r_next_rev <= n_next_rev;
            r_run      <= n_run;
            r_dir      <= n_dir;
            r_magnet   <= n_magnet;
            r_beacon   <= n_beacon;
        end
    end

    always_comb begin
        case (n_state)
            ST_OPEN:        o_status.mode = MODE_OPEN;
            ST_DEBOUNCING:  o_status.mode = MODE_DEBOUNCING;
            ST_CLOSED:      o_status.mode = MODE_CLOSED;
            ST_DISENGAGING: o_status.mode = MODE_DISENGAGING;
            default:        o_status.mode = MODE_OPEN;
        endcase
        if (!n_run) begin
            o_status.motor_duty_out = '0;
        end else if (i_cfg.motor_duty > DUTY_MAX) begin
            o_status.motor_duty_out = DUTY_MAX;
        end else begin
            o_status.motor_duty_out = i_cfg.motor_duty;
        end
        o_status.motor_reverse = n_dir;
        o_status.magnet_on     = n_magnet;
        o_status.beacon_on     = n_beacon;
    end

endmodule
`default_nettype wire

FILE: sv/wire_clamp_motor_sequencer_top.sv
// top level: request register, sequencer core, result register and settings
`default_nettype none
// Wire clamp motor sequencer. Each request is one event (millisecond tick, cable
// pin edge, encoder edge, engage, disengage) and yields exactly one status result
// (mode, motor duty, direction, magnet and beacon drive). A request is taken into
// an input register, evaluated against the clamp state by one pass of next-state
// logic, and the status lands in the result register when the request fires.
// Throughput is one request per clock while o_rsp.ready holds: the state update
// and the result register load happen at the same edge, so the following request
// already sees the new state. Requests keep flowing while a result waits, as
// long as the result register is being drained; i_req.ready follows o_rsp.ready
// combinationally through the two stages. Settings are written through i_cfg
// (always ready) and must only change while no request is in flight.
// COUNTER_BITS sets the width of the saturating encoder counter.
module wire_clamp_motor_sequencer_top import wcms_pkg::*; #(
    parameter int COUNTER_BITS = COUNTER_BITS_DEF
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    wcms_cfg_if.sink    i_cfg,
    wcms_req_if.sink    i_req,
    wcms_rsp_if.source  o_rsp
);

    // input stage
    logic            r_in_valid;
    logic [OP_W-1:0] r_op;
    logic            r_pin;

    // result stage
    logic            r_out_valid;
    t_status         r_status;

    t_cfg            cfg;
    t_status         status;
    logic            advance;   // result register can take a new status
    logic            fire;      // request in input stage is evaluated this cycle

    assign advance     = !r_out_valid || o_rsp.ready;
    assign fire        = r_in_valid && advance;
    assign i_req.ready = !r_in_valid || advance;
    assign i_cfg.ready = 1'b1;

    wcms_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_valid (i_cfg.valid),
        .i_wr_index (i_cfg.index),
        .i_wr_data  (i_cfg.data),
        .o_cfg      (cfg)
    );

    wcms_core #(
        .COUNTER_BITS (COUNTER_BITS)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (fire),
        .i_operation (r_op),
        .i_pin_level (r_pin),
        .i_cfg       (cfg),
        .o_status    (status)
    );

    // request register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_req.ready) begin
            r_in_valid <= i_req.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.valid && i_req.ready) begin
            r_op  <= i_req.operation;
            r_pin <= i_req.pin_level;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_status <= status;
        end
    end

    assign o_rsp.valid          = r_out_valid;
    assign o_rsp.mode           = r_status.mode;
    assign o_rsp.motor_duty_out = r_status.motor_duty_out;
    assign o_rsp.motor_reverse  = r_status.motor_reverse;
    assign o_rsp.magnet_on      = r_status.magnet_on;
    assign o_rsp.beacon_on      = r_status.beacon_on;

    // a stalled request in the input stage is neither lost nor changed
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !advance |=> r_in_valid && $stable(r_op) && $stable(r_pin))
        else $error("input stage lost or changed a stalled request");

    // duty never exceeds one hundred percent
    a_duty_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid |-> o_rsp.motor_duty_out <= DUTY_MAX)
        else $error("motor duty above maximum");

    // when closed, magnet and beacon are both off
    a_closed_off: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid && o_rsp.mode == MODE_CLOSED |-> !o_rsp.magnet_on && !o_rsp.beacon_on)
        else $error("magnet or beacon on while closed");

endmodule
`default_nettype wire
